>>> rtl/utrc_pkg.sv
`timescale 1ns / 1ps
package utrc_pkg;

  // Coordinate and derived operand widths.
  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int SPAN_W      = COORD_WIDTH + 3;
  localparam int SIDE_W      = COORD_WIDTH + 4;

  // Configuration register widths and reset values.
  localparam int RADIUS_W = 20;
  localparam int EPS_W    = 32;
  localparam int RR4_W    = 2 * RADIUS_W + 3;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam logic [RADIUS_W-1:0] MIN_RADIUS_RESET = 20'd505;
  localparam logic [EPS_W-1:0]    CROSS_EPS_RESET  = 32'd1;

  // Register indexes.
  localparam logic REG_MIN_RADIUS = 1'b0;
  localparam logic REG_CROSS_EPS  = 1'b1;

  // Decision codes.
  localparam logic [2:0] CASE_NOT_UTURN   = 3'd0;
  localparam logic [2:0] CASE_NO_GEOMETRY = 3'd1;
  localparam logic [2:0] CASE_MID_CENTER  = 3'd2;
  localparam logic [2:0] CASE_SIDE_CENTER = 3'd3;
  localparam logic [2:0] CASE_PARALLEL    = 3'd4;
  localparam logic [2:0] CASE_GENERAL     = 3'd5;

  // Multiplier limb width and work queue depth.
  localparam int LIMB_W      = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic                          is_u_turn;
    logic                          has_geometry;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] mid_x;
    logic signed [COORD_WIDTH-1:0] mid_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
  } lane_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] decision_case;
  } verdict_t;

  // One classified item waiting for the arithmetic pipeline.
  typedef struct packed {
    logic                     decided;
    logic [2:0]               early_case;
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uy;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vy;
    logic signed [DIFF_W-1:0] ox;
    logic signed [DIFF_W-1:0] oy;
    logic signed [SPAN_W-1:0] ax;
    logic signed [SPAN_W-1:0] ay;
    logic signed [SIDE_W-1:0] bx;
    logic signed [SIDE_W-1:0] by;
  } work_t;

  typedef struct packed {
    logic signed [RR4_W-1:0] rr4;
    logic [EPS_W-1:0]        eps;
  } cfg_t;

  // Register stages of a limb-serial multiplier: one partial product per stage.
  function automatic int mul_lat(int aw, int bw);
    return ((aw + LIMB_W - 1) / LIMB_W) * ((bw + LIMB_W - 1) / LIMB_W) + 2;
  endfunction

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/utrc_cfg.sv
`timescale 1ns / 1ps
module utrc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [utrc_pkg::ADDR_W-1:0]  paddr,
  input  logic [utrc_pkg::DATA_W-1:0]  pwdata,
  output logic [utrc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output utrc_pkg::cfg_t               cfg
);

  logic [utrc_pkg::RADIUS_W-1:0]   min_radius;
  logic [utrc_pkg::EPS_W-1:0]      cross_epsilon;
  logic [2*utrc_pkg::RADIUS_W-1:0] radius_sq;
  logic                            wr;
  logic                            reg_idx;

  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  // Register writes in the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_radius    <= utrc_pkg::MIN_RADIUS_RESET;
      cross_epsilon <= utrc_pkg::CROSS_EPS_RESET;
    end else if (wr) begin
      unique case (reg_idx)
        utrc_pkg::REG_MIN_RADIUS: min_radius    <= pwdata[utrc_pkg::RADIUS_W-1:0];
        utrc_pkg::REG_CROSS_EPS:  cross_epsilon <= pwdata[utrc_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  assign prdata = (reg_idx == utrc_pkg::REG_CROSS_EPS) ? utrc_pkg::DATA_W'(cross_epsilon)
                                                       : utrc_pkg::DATA_W'(min_radius);

  // The squared limit 4*R^2 is kept in a register so no datapath stage squares it.
  assign radius_sq = min_radius * min_radius;

  always_ff @(posedge clk) begin
    cfg.rr4 <= $signed({1'b0, radius_sq, 2'b00});
    cfg.eps <= cross_epsilon;
  end

endmodule

>>> rtl/utrc_front.sv
`timescale 1ns / 1ps
module utrc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  utrc_pkg::lane_t         lane,
  input  logic                    q_pop,
  output logic                    q_empty,
  output utrc_pkg::work_t         q_head
);

  localparam int QP_W = $clog2(utrc_pkg::QUEUE_DEPTH);

  utrc_pkg::work_t                     slot [utrc_pkg::QUEUE_DEPTH];
  utrc_pkg::work_t                     entry;
  logic [QP_W-1:0]                     wr_ptr;
  logic [QP_W-1:0]                     rd_ptr;
  logic [QP_W:0]                       count;
  logic                                do_push;
  logic                                do_pop;
  logic signed [utrc_pkg::COORD_WIDTH-1:0] sx, sy, mx, my, ex, ey;

  assign sx = lane.start_x;
  assign sy = lane.start_y;
  assign mx = lane.mid_x;
  assign my = lane.mid_y;
  assign ex = lane.end_x;
  assign ey = lane.end_y;

  // Classify on the flags and form the difference vectors.
  always_comb begin
    entry.decided    = !lane.is_u_turn || !lane.has_geometry;
    entry.early_case = lane.is_u_turn ? utrc_pkg::CASE_NO_GEOMETRY
                                      : utrc_pkg::CASE_NOT_UTURN;
    entry.ux = utrc_pkg::DIFF_W'(mx) - utrc_pkg::DIFF_W'(sx);
    entry.uy = utrc_pkg::DIFF_W'(my) - utrc_pkg::DIFF_W'(sy);
    entry.vx = utrc_pkg::DIFF_W'(ex) - utrc_pkg::DIFF_W'(mx);
    entry.vy = utrc_pkg::DIFF_W'(ey) - utrc_pkg::DIFF_W'(my);
    entry.ox = utrc_pkg::DIFF_W'(sx) - utrc_pkg::DIFF_W'(ex);
    entry.oy = utrc_pkg::DIFF_W'(sy) - utrc_pkg::DIFF_W'(ey);
    entry.ax = utrc_pkg::SPAN_W'(mx) + utrc_pkg::SPAN_W'(ex)
             - (utrc_pkg::SPAN_W'(sx) <<< 1);
    entry.ay = utrc_pkg::SPAN_W'(my) + utrc_pkg::SPAN_W'(ey)
             - (utrc_pkg::SPAN_W'(sy) <<< 1);
    entry.bx = utrc_pkg::SIDE_W'(entry.ax) - (utrc_pkg::SIDE_W'(entry.vy) <<< 1);
    entry.by = utrc_pkg::SIDE_W'(entry.ay) + (utrc_pkg::SIDE_W'(entry.vx) <<< 1);
  end

  assign full    = (count == (QP_W+1)'(utrc_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && !q_empty;
  assign q_head  = slot[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= entry;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QP_W+1)'(utrc_pkg::QUEUE_DEPTH))
    else $error("work queue count above depth");

  a_count_push: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("work queue lost a transfer");

endmodule

>>> rtl/utrc_mul.sv
`timescale 1ns / 1ps
module utrc_mul #(
  parameter int AW  = 33,
  parameter int BW  = 33,
  parameter int LAT = 6
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LW   = utrc_pkg::LIMB_W;
  localparam int NA   = (AW + LW - 1) / LW;
  localparam int NB   = (BW + LW - 1) / LW;
  localparam int NPP  = NA * NB;
  localparam int ACCW = LW * (NA + NB);
  localparam int PW   = AW + BW;
  localparam int NRES = LAT - NPP - 1;

  logic [NA*LW-1:0]   ma   [NPP];
  logic [NB*LW-1:0]   mb   [NPP];
  logic               neg  [NPP+1];
  logic [ACCW-1:0]    acc  [NPP];
  logic signed [PW-1:0] res [NRES];
  logic [AW-1:0]      abs_a;
  logic [BW-1:0]      abs_b;

  // Sign and magnitude split.
  assign abs_a = a[AW-1] ? $unsigned(-a) : $unsigned(a);
  assign abs_b = b[BW-1] ? $unsigned(-b) : $unsigned(b);

  always_ff @(posedge clk) begin
    if (en) begin
      ma[0]  <= (NA*LW)'(abs_a);
      mb[0]  <= (NB*LW)'(abs_b);
      neg[0] <= a[AW-1] ^ b[BW-1];
    end
  end

  // Operands and sign travel with the partial sum.
  for (genvar k = 1; k < NPP; k++) begin : g_opnd
    always_ff @(posedge clk) begin
      if (en) begin
        ma[k] <= ma[k-1];
        mb[k] <= mb[k-1];
      end
    end
  end

  for (genvar k = 1; k <= NPP; k++) begin : g_sign
    always_ff @(posedge clk) begin
      if (en) begin
        neg[k] <= neg[k-1];
      end
    end
  end

  // One limb-by-limb partial product per stage.
  for (genvar k = 0; k < NPP; k++) begin : g_pp
    localparam int I = k / NB;
    localparam int J = k % NB;
    logic [2*LW-1:0] pp;
    assign pp = ma[k][I*LW +: LW] * mb[k][J*LW +: LW];
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= ACCW'(pp) << (LW * (I + J));
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= acc[k-1] + (ACCW'(pp) << (LW * (I + J)));
        end
      end
    end
  end

  // Restore the sign, then pad to the requested latency.
  always_ff @(posedge clk) begin
    if (en) begin
      res[0] <= neg[NPP] ? $signed(-PW'(acc[NPP-1])) : $signed(PW'(acc[NPP-1]));
    end
  end

  for (genvar j = 1; j < NRES; j++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        res[j] <= res[j-1];
      end
    end
  end

  assign p = res[NRES-1];

endmodule

>>> rtl/utrc_back.sv
`timescale 1ns / 1ps
module utrc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  utrc_pkg::work_t   q_head,
  output logic              q_pop,
  input  utrc_pkg::cfg_t    cfg,
  input  logic              pop,
  output logic              empty,
  output utrc_pkg::verdict_t verdict
);

  localparam int DW  = utrc_pkg::DIFF_W;
  localparam int SW  = utrc_pkg::SPAN_W;
  localparam int BW  = utrc_pkg::SIDE_W;
  localparam int RW  = utrc_pkg::RR4_W;
  localparam int CDW = 2 * DW + 1;
  localparam int C2W = CDW + 2;
  localparam int NAW = 2 * SW + 1;
  localparam int NBW = 2 * BW + 1;
  localparam int GW  = CDW + SW + 1;
  localparam int D2W = 2 * CDW;
  localparam int NGW = 2 * GW + 1;
  localparam int RHW = RW + D2W;
  localparam int LA  = utrc_pkg::max2(utrc_pkg::mul_lat(DW, DW), utrc_pkg::mul_lat(BW, BW));
  localparam int LB  = utrc_pkg::max2(utrc_pkg::mul_lat(CDW, CDW),
                                      utrc_pkg::mul_lat(CDW, SW));
  localparam int LC  = utrc_pkg::max2(utrc_pkg::mul_lat(GW, GW), utrc_pkg::mul_lat(RW, D2W));

  typedef struct packed {
    logic                 decided;
    logic [2:0]           early_case;
    logic signed [SW-1:0] ax;
    logic signed [SW-1:0] ay;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
  } geo_t;

  logic en;

  // Phase A products.
  logic signed [2*DW-1:0] p_oxux, p_oyuy, p_vxuy, p_vyux;
  logic signed [2*SW-1:0] p_axax, p_ayay;
  logic signed [2*BW-1:0] p_bxbx, p_byby;
  logic [LA-1:0]          va;
  geo_t                   ga [LA];

  // Decision stages.
  logic                  v1, v2, v3, v4;
  geo_t                  g1, g2, g3, g4;
  logic signed [CDW-1:0] c1_s1, d_s1, c1_s2, d_s2, c1_s3, d_s3, c1_s4, d_s4;
  logic signed [NAW-1:0] na_s1;
  logic signed [NBW-1:0] nb_s1;
  logic signed [C2W-1:0] c2_s2;
  logic [CDW-1:0]        ac1_s2, ad_s2;
  logic                  dz_s2, acc_a_s2, acc_b_s2;
  logic [C2W-1:0]        ac2_s3;
  logic                  t1_s3, t3_s3, acc_a_s3, acc_b_s3;
  logic                  t2;
  utrc_pkg::verdict_t    dec, vd4;

  // Phase B products.
  logic signed [CDW+SW-1:0] p_dax, p_day;
  logic signed [CDW+DW-1:0] p_c1vy, p_c1vx;
  logic signed [D2W-1:0]    p_dd;
  logic [LB-1:0]            vb;
  utrc_pkg::verdict_t       sb_b [LB];
  logic                     v5;
  logic signed [GW-1:0]     gx, gy;
  logic signed [D2W-1:0]    d2_s5;
  utrc_pkg::verdict_t       vd5;

  // Phase C products.
  logic signed [2*GW-1:0] p_gx2, p_gy2;
  logic signed [RHW-1:0]  p_rhs;
  logic [LC-1:0]          vc;
  utrc_pkg::verdict_t     sb_c [LC];
  logic                   v6;
  logic signed [NGW-1:0]  ng_s6;
  logic signed [RHW-1:0]  rhs_s6;
  utrc_pkg::verdict_t     vd6;
  logic                   o_vld;

  // The whole pipeline moves unless a finished result is waiting and not popped.
  assign en    = !o_vld || pop;
  assign q_pop = en && !q_empty;
  assign empty = !o_vld;

  // Phase A: cross-product and squared-length terms.
  utrc_mul #(.AW(DW), .BW(DW), .LAT(LA)) u_oxux (.clk, .en, .a(q_head.ox), .b(q_head.ux),
                                                  .p(p_oxux));
  utrc_mul #(.AW(DW), .BW(DW), .LAT(LA)) u_oyuy (.clk, .en, .a(q_head.oy), .b(q_head.uy),
                                                  .p(p_oyuy));
  utrc_mul #(.AW(DW), .BW(DW), .LAT(LA)) u_vxuy (.clk, .en, .a(q_head.vx), .b(q_head.uy),
                                                  .p(p_vxuy));
  utrc_mul #(.AW(DW), .BW(DW), .LAT(LA)) u_vyux (.clk, .en, .a(q_head.vy), .b(q_head.ux),
                                                  .p(p_vyux));
  utrc_mul #(.AW(SW), .BW(SW), .LAT(LA)) u_axax (.clk, .en, .a(q_head.ax), .b(q_head.ax),
                                                  .p(p_axax));
  utrc_mul #(.AW(SW), .BW(SW), .LAT(LA)) u_ayay (.clk, .en, .a(q_head.ay), .b(q_head.ay),
                                                  .p(p_ayay));
  utrc_mul #(.AW(BW), .BW(BW), .LAT(LA)) u_bxbx (.clk, .en, .a(q_head.bx), .b(q_head.bx),
                                                  .p(p_bxbx));
  utrc_mul #(.AW(BW), .BW(BW), .LAT(LA)) u_byby (.clk, .en, .a(q_head.by), .b(q_head.by),
                                                  .p(p_byby));

  // Side data aligned with phase A.
  always_ff @(posedge clk) begin
    if (en) begin
      ga[0].decided    <= q_head.decided;
      ga[0].early_case <= q_head.early_case;
      ga[0].ax         <= q_head.ax;
      ga[0].ay         <= q_head.ay;
      ga[0].vx         <= q_head.vx;
      ga[0].vy         <= q_head.vy;
      for (int k = 1; k < LA; k++) begin
        ga[k] <= ga[k-1];
      end
    end
  end

  // Stage 1: cross products and squared lengths.
  always_ff @(posedge clk) begin
    if (en) begin
      g1    <= ga[LA-1];
      c1_s1 <= CDW'(p_oxux) + CDW'(p_oyuy);
      d_s1  <= CDW'(p_vxuy) - CDW'(p_vyux);
      na_s1 <= NAW'(p_axax) + NAW'(p_ayay);
      nb_s1 <= NBW'(p_bxbx) + NBW'(p_byby);
    end
  end

  // Stage 2: second cross, magnitudes and radius checks for the special centers.
  always_ff @(posedge clk) begin
    if (en) begin
      g2       <= g1;
      c1_s2    <= c1_s1;
      d_s2     <= d_s1;
      c2_s2    <= C2W'(c1_s1) - (C2W'(d_s1) <<< 1);
      ac1_s2   <= c1_s1[CDW-1] ? $unsigned(-c1_s1) : $unsigned(c1_s1);
      ad_s2    <= d_s1[CDW-1] ? $unsigned(-d_s1) : $unsigned(d_s1);
      dz_s2    <= (d_s1 == '0);
      acc_a_s2 <= (na_s1 >= cfg.rr4);
      acc_b_s2 <= (nb_s1 >= cfg.rr4);
    end
  end

  // Stage 3: near-zero tests on the first cross and the determinant.
  always_ff @(posedge clk) begin
    if (en) begin
      g3       <= g2;
      c1_s3    <= c1_s2;
      d_s3     <= d_s2;
      ac2_s3   <= c2_s2[C2W-1] ? $unsigned(-c2_s2) : $unsigned(c2_s2);
      t1_s3    <= (ac1_s2 < CDW'({cfg.eps, 1'b0}));
      t3_s3    <= dz_s2 || (ad_s2 < CDW'(cfg.eps));
      acc_a_s3 <= acc_a_s2;
      acc_b_s3 <= acc_b_s2;
    end
  end

  // Case selection in priority order.
  always_comb begin
    t2 = (ac2_s3 < C2W'({cfg.eps, 1'b0}));
    if (g3.decided) begin
      dec.accepted      = 1'b0;
      dec.decision_case = g3.early_case;
    end else if (t1_s3) begin
      dec.accepted      = acc_a_s3;
      dec.decision_case = utrc_pkg::CASE_MID_CENTER;
    end else if (t2) begin
      dec.accepted      = acc_b_s3;
      dec.decision_case = utrc_pkg::CASE_SIDE_CENTER;
    end else if (t3_s3) begin
      dec.accepted      = 1'b1;
      dec.decision_case = utrc_pkg::CASE_PARALLEL;
    end else begin
      dec.accepted      = 1'b0;
      dec.decision_case = utrc_pkg::CASE_GENERAL;
    end
  end

  // Stage 4: decision register.
  always_ff @(posedge clk) begin
    if (en) begin
      g4    <= g3;
      c1_s4 <= c1_s3;
      d_s4  <= d_s3;
      vd4   <= dec;
    end
  end

  // Phase B: scaled center offset terms and the squared determinant.
  utrc_mul #(.AW(CDW), .BW(SW), .LAT(LB)) u_dax (.clk, .en, .a(d_s4), .b(g4.ax), .p(p_dax));
  utrc_mul #(.AW(CDW), .BW(SW), .LAT(LB)) u_day (.clk, .en, .a(d_s4), .b(g4.ay), .p(p_day));
  utrc_mul #(.AW(CDW), .BW(DW), .LAT(LB)) u_c1vy (.clk, .en, .a(c1_s4), .b(g4.vy),
                                                   .p(p_c1vy));
  utrc_mul #(.AW(CDW), .BW(DW), .LAT(LB)) u_c1vx (.clk, .en, .a(c1_s4), .b(g4.vx),
                                                   .p(p_c1vx));
  utrc_mul #(.AW(CDW), .BW(CDW), .LAT(LB)) u_dd (.clk, .en, .a(d_s4), .b(d_s4), .p(p_dd));

  always_ff @(posedge clk) begin
    if (en) begin
      sb_b[0] <= vd4;
      for (int k = 1; k < LB; k++) begin
        sb_b[k] <= sb_b[k-1];
      end
    end
  end

  // Stage 5: scaled offset from the start point to the center.
  always_ff @(posedge clk) begin
    if (en) begin
      gx    <= GW'(p_dax) - GW'(p_c1vy);
      gy    <= GW'(p_day) + GW'(p_c1vx);
      d2_s5 <= p_dd;
      vd5   <= sb_b[LB-1];
    end
  end

  // Phase C: squared distance and scaled limit.
  utrc_mul #(.AW(GW), .BW(GW), .LAT(LC)) u_gx2 (.clk, .en, .a(gx), .b(gx), .p(p_gx2));
  utrc_mul #(.AW(GW), .BW(GW), .LAT(LC)) u_gy2 (.clk, .en, .a(gy), .b(gy), .p(p_gy2));
  utrc_mul #(.AW(RW), .BW(D2W), .LAT(LC)) u_rhs (.clk, .en, .a(cfg.rr4), .b(d2_s5),
                                                  .p(p_rhs));

  always_ff @(posedge clk) begin
    if (en) begin
      sb_c[0] <= vd5;
      for (int k = 1; k < LC; k++) begin
        sb_c[k] <= sb_c[k-1];
      end
    end
  end

  // Stage 6: sum of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      ng_s6  <= NGW'(p_gx2) + NGW'(p_gy2);
      rhs_s6 <= p_rhs;
      vd6    <= sb_c[LC-1];
    end
  end

  // Output register: the general case is settled by the final compare.
  always_ff @(posedge clk) begin
    if (en) begin
      verdict.decision_case <= vd6.decision_case;
      verdict.accepted      <= (vd6.decision_case == utrc_pkg::CASE_GENERAL) ?
                               (ng_s6 >= rhs_s6) : vd6.accepted;
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      vb    <= '0;
      v5    <= 1'b0;
      vc    <= '0;
      v6    <= 1'b0;
      o_vld <= 1'b0;
    end else if (en) begin
      va    <= {va[LA-2:0], !q_empty};
      v1    <= va[LA-1];
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      vb    <= {vb[LB-2:0], v4};
      v5    <= vb[LB-1];
      vc    <= {vc[LC-2:0], v5};
      v6    <= vc[LC-1];
      o_vld <= v6;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> (v6 == $past(v6)) && (vc == $past(vc)) && (va == $past(va)))
    else $error("pipeline moved during a stall");

  a_parallel_acc: assert property (@(posedge clk) disable iff (rst)
    o_vld && (verdict.decision_case == utrc_pkg::CASE_PARALLEL) |-> verdict.accepted)
    else $error("parallel bisectors not accepted");

  a_early_reject: assert property (@(posedge clk) disable iff (rst)
    o_vld && (verdict.decision_case == utrc_pkg::CASE_NOT_UTURN ||
              verdict.decision_case == utrc_pkg::CASE_NO_GEOMETRY) |-> !verdict.accepted)
    else $error("early case accepted");

  a_geom_case: assert property (@(posedge clk) disable iff (rst)
    v4 && !g4.decided |-> vd4.decision_case != utrc_pkg::CASE_NOT_UTURN &&
                          vd4.decision_case != utrc_pkg::CASE_NO_GEOMETRY)
    else $error("geometric item given a flag case");

endmodule

>>> rtl/u_turn_radius_check_core.sv
`timescale 1ns / 1ps
// A lane passes the queue, phase A, stages 1-4, phase B, stage 5, phase C, stage 6 and
// the output register; phases use limb-serial multipliers, one 32x32 product per stage.
// Throughput: one lane per cycle, held only while a finished result is not popped.
// The four-entry work queue keeps taking lanes while the pipeline stalls, until full.
// Reset (synchronous, active high) empties the queue and pipeline and sets
// min_radius to 505 and cross_epsilon to 1.
module u_turn_radius_check_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  utrc_pkg::lane_t             lane,
  output logic                        empty,
  input  logic                        pop,
  output utrc_pkg::verdict_t          verdict,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [utrc_pkg::ADDR_W-1:0] paddr,
  input  logic [utrc_pkg::DATA_W-1:0] pwdata,
  output logic [utrc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  utrc_pkg::cfg_t  cfg;
  utrc_pkg::work_t q_head;
  logic            q_empty;
  logic            q_pop;

  // Configuration registers.
  utrc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Classification and work queue.
  utrc_front u_front (
    .clk, .rst, .push, .full, .lane, .q_pop, .q_empty, .q_head
  );

  // Arithmetic pipeline and result register.
  utrc_back u_back (
    .clk, .rst, .q_empty, .q_head, .q_pop, .cfg, .pop, .empty, .verdict
  );

endmodule

>>> verif/utrc_checker.sv
`timescale 1ns / 1ps
module utrc_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  utrc_pkg::lane_t             lane,
  input  logic                        empty,
  input  logic                        pop,
  input  utrc_pkg::verdict_t          verdict,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [utrc_pkg::ADDR_W-1:0] paddr,
  input  logic [utrc_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending
);

  // Shadow copy of the configuration registers.
  logic [utrc_pkg::RADIUS_W-1:0] radius_q;
  logic [utrc_pkg::EPS_W-1:0]    eps_q;
  utrc_pkg::verdict_t            verdict_q[$];

  task automatic report_mismatch(input string what, input utrc_pkg::verdict_t got,
                                 input utrc_pkg::verdict_t want);
    $display("MISMATCH %s: got acc=%0b case=%0d, want acc=%0b case=%0d", what,
             got.accepted, got.decision_case, want.accepted, want.decision_case);
    fail_count++;
  endtask

  // Exact integer circumcircle decision; 200 signed bits covers every product.
  function automatic utrc_pkg::verdict_t judge_lane(utrc_pkg::lane_t l,
                                                    logic [utrc_pkg::RADIUS_W-1:0] r,
                                                    logic [utrc_pkg::EPS_W-1:0] e);
    logic signed [199:0] ux, uy, vx, vy, ox, oy, ax, ay, c1, c2, d, bx, by, gx, gy;
    logic signed [199:0] lim1, lim2, rr4, ac1, ac2, ad;
    utrc_pkg::verdict_t v;
    v.accepted = 1'b0;
    if (!l.is_u_turn) begin
      v.decision_case = utrc_pkg::CASE_NOT_UTURN;
      return v;
    end
    if (!l.has_geometry) begin
      v.decision_case = utrc_pkg::CASE_NO_GEOMETRY;
      return v;
    end
    ux = 200'(l.mid_x) - 200'(l.start_x);
    uy = 200'(l.mid_y) - 200'(l.start_y);
    vx = 200'(l.end_x) - 200'(l.mid_x);
    vy = 200'(l.end_y) - 200'(l.mid_y);
    ox = 200'(l.start_x) - 200'(l.end_x);
    oy = 200'(l.start_y) - 200'(l.end_y);
    ax = 200'(l.mid_x) + 200'(l.end_x) - 2 * 200'(l.start_x);
    ay = 200'(l.mid_y) + 200'(l.end_y) - 2 * 200'(l.start_y);
    c1 = ox * ux + oy * uy;
    d  = vx * uy - vy * ux;
    c2 = c1 - 2 * d;
    lim1 = 200'(e);
    lim2 = 2 * lim1;
    rr4 = 4 * 200'(r) * 200'(r);
    ac1 = c1 < 0 ? -c1 : c1;
    ac2 = c2 < 0 ? -c2 : c2;
    ad  = d < 0 ? -d : d;
    if (ac1 < lim2) begin
      v.decision_case = utrc_pkg::CASE_MID_CENTER;
      v.accepted = (ax * ax + ay * ay) >= rr4;
    end else if (ac2 < lim2) begin
      bx = ax - 2 * vy;
      by = ay + 2 * vx;
      v.decision_case = utrc_pkg::CASE_SIDE_CENTER;
      v.accepted = (bx * bx + by * by) >= rr4;
    end else if (d == 0 || ad < lim1) begin
      v.decision_case = utrc_pkg::CASE_PARALLEL;
      v.accepted = 1'b1;
    end else begin
      gx = d * ax - c1 * vy;
      gy = d * ay + c1 * vx;
      v.decision_case = utrc_pkg::CASE_GENERAL;
      v.accepted = (gx * gx + gy * gy) >= rr4 * d * d;
    end
    return v;
  endfunction

  // Track register writes, predict at each input transfer, check each output transfer.
  always @(posedge clk) begin
    if (rst) begin
      radius_q <= utrc_pkg::MIN_RADIUS_RESET;
      eps_q <= utrc_pkg::CROSS_EPS_RESET;
      fail_count = 0;
      verdict_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == utrc_pkg::REG_MIN_RADIUS) radius_q <= pwdata[utrc_pkg::RADIUS_W-1:0];
        else if (paddr[2] == utrc_pkg::REG_CROSS_EPS) eps_q <= pwdata[utrc_pkg::EPS_W-1:0];
      end
      if (!empty && pop) begin
        if (verdict_q.size() == 0) report_mismatch("unexpected result", verdict, '0);
        else begin
          utrc_pkg::verdict_t want;
          want = verdict_q.pop_front();
          if (verdict !== want) report_mismatch("field", verdict, want);
        end
      end
      if (push && !full) verdict_q.push_back(judge_lane(lane, radius_q, eps_q));
    end
    pending = verdict_q.size();
  end
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;

  logic clk, rst, push, full, empty, pop, psel, penable, pwrite, pready;
  utrc_pkg::lane_t lane;
  utrc_pkg::verdict_t verdict;
  logic [utrc_pkg::ADDR_W-1:0] paddr;
  logic [utrc_pkg::DATA_W-1:0] pwdata, prdata;
  int fail_count, pending;
  bit quiet;      // no idling in the last phase
  bit hold_long;  // request a long receiver hold-off
  int lanes_sent;

  u_turn_radius_check_core dut (.*);

  utrc_checker chk (.clk, .rst, .push, .full, .lane, .empty, .pop, .verdict, .psel,
                    .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random pop bursts, plus one long hold-off when asked.
  initial begin
    int n;
    pop = 0;
    @(negedge clk);
    forever begin
      if (hold_long) begin
        pop <= 0;
        repeat (300) @(negedge clk);
        hold_long = 0;
      end
      if (!quiet && $urandom_range(3) == 0) begin
        pop <= 0;
        n = $urandom_range(1, 14);
        repeat (n) @(negedge clk);
      end else begin
        pop <= 1;
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic reg_write(input int idx, input logic [utrc_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= utrc_pkg::ADDR_W'(4 * idx);
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Stop offering lanes, wait until every expected verdict has come, then let the
  // pipeline settle.
  task automatic drain();
    push <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Offer one lane and hold it until the transfer happens; push stays high so
  // lanes can follow back to back.
  task automatic send_lane(input utrc_pkg::lane_t l, input bit gaps);
    if (gaps && !quiet && $urandom_range(4) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    push <= 1;
    lane <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    lanes_sent++;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 4000)) - 2000);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  // Mostly flagged U-turns: circle-ish arcs, slanted two-step paths or random points.
  function automatic utrc_pkg::lane_t rand_lane();
    utrc_pkg::lane_t l;
    int m, cx, cy, rr, k;
    l.is_u_turn = $urandom_range(9) != 0;
    l.has_geometry = $urandom_range(9) != 0;
    m = $urandom_range(7);
    if (m < 4) begin
      cx = $signed($urandom_range(0, 2000000)) - 1000000;
      cy = $signed($urandom_range(0, 2000000)) - 1000000;
      rr = $urandom_range(1, 2000);
      l.start_x = cx + rr; l.start_y = cy + $signed($urandom_range(0, 20)) - 10;
      l.mid_x = cx + $signed($urandom_range(0, 20)) - 10; l.mid_y = cy + rr;
      l.end_x = cx - rr; l.end_y = cy + $signed($urandom_range(0, 20)) - 10;
    end else if (m == 4) begin
      k = $urandom_range(1, 500);
      l.start_x = rand_coord(3); l.start_y = rand_coord(3);
      l.mid_x = l.start_x + k; l.mid_y = l.start_y + 2 * k;
      l.end_x = l.mid_x + $urandom_range(0, 1000); l.end_y = l.mid_y + 2 * k;
    end else begin
      l.start_x = rand_coord(m - 5); l.start_y = rand_coord(m - 5);
      l.mid_x = rand_coord(m - 5); l.mid_y = rand_coord(m - 5);
      l.end_x = rand_coord($urandom_range(3)); l.end_y = rand_coord($urandom_range(3));
    end
    return l;
  endfunction

  function automatic utrc_pkg::lane_t mk(int sx, int sy, int mx, int my, int ex, int ey);
    utrc_pkg::lane_t l;
    l = '{1'b1, 1'b1, sx, sy, mx, my, ex, ey};
    return l;
  endfunction

  initial begin
    utrc_pkg::lane_t dl[$];
    utrc_pkg::lane_t l;
    push = 0; lane = '0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    quiet = 0; hold_long = 0; lanes_sent = 0;
    rst = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed lanes: flags, mid-center, parallel, general, coordinate extremes.
    l = mk(1, 2, 3, 4, 5, 6); l.is_u_turn = 0; dl.push_back(l);
    l = mk(1, 2, 3, 4, 5, 6); l.has_geometry = 0; dl.push_back(l);
    dl.push_back(mk(0, 0, 0, 0, 0, 0));
    dl.push_back(mk(-600, 0, 0, 600, 600, 0));
    dl.push_back(mk(-400, 0, 0, 400, 400, 0));
    dl.push_back(mk(0, 0, 1000, 0, 1000, 1000));
    dl.push_back(mk(0, 0, 100, 0, 100, 100));
    dl.push_back(mk(0, 0, 100, 100, 200, 200));
    dl.push_back(mk(0, 0, 100, 100, 0, 0));
    dl.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                    32'h80000000, 32'h7fffffff));
    dl.push_back(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff));
    dl.push_back(mk(-1, -1, -1, -1, -1, -1));
    dl.push_back(mk(0, 0, 3, 1, 5, 0));
    foreach (dl[i]) send_lane(dl[i], 0);
    drain();

    // Extreme and random register values, then random lanes. Registers change
    // only once every lane of the previous phase has come back.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin reg_write(0, 0); reg_write(1, 0); end
        1: begin reg_write(0, 20'hfffff); reg_write(1, 32'hffffffff); end
        2: begin reg_write(0, $urandom_range(100, 3000)); reg_write(1, $urandom_range(0, 50)); end
        3: begin reg_write(0, $urandom); reg_write(1, $urandom); end
        4: begin reg_write(0, 505); reg_write(1, 1); end
        default: begin reg_write(0, $urandom_range(0, 2000)); reg_write(1, $urandom_range(5));
          quiet = 1; end
      endcase
      for (int i = 0; i < 330; i++) begin
        if (ph == 1 && i == 50) hold_long = 1;
        send_lane(rand_lane(), 1);
      end
      if (ph == 2) drain();  // sender pauses until every verdict is back
    end
    drain();
    $display("Sent %0d lanes over six register settings, including extreme radius and epsilon.",
             lanes_sent);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

>>> u_turn_radius_check_core.f
rtl/utrc_pkg.sv
rtl/utrc_cfg.sv
rtl/utrc_front.sv
rtl/utrc_mul.sv
rtl/utrc_back.sv
rtl/u_turn_radius_check_core.sv
verif/utrc_checker.sv
verif/tb.sv
